// ===== sv/rwp_pkg.sv =====
// Shared types and constants for the rainbow wave pixel generator.
package rwp_pkg;

  localparam int TIME_W       = 32;
  localparam int PERIOD_W     = 16;
  localparam int LED_CNT_W    = 7;
  localparam int IDX_W        = 6;
  localparam int CH_W         = 8;
  localparam int MAX_LEDS     = 64;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int IN_TDATA_W   = 32;
  localparam int OUT_PAYLOAD_W = IDX_W + 3 * CH_W;
  localparam int OUT_TDATA_W  = ((OUT_PAYLOAD_W + 7) / 8) * 8;
  localparam int FIFO_DEPTH   = 2;

  localparam logic [CH_W-1:0] CH_MAX     = 8'd255;
  localparam logic [CH_W-1:0] HUE_SECTOR = 8'd43;
  localparam logic [CH_W-1:0] REM_SCALE  = 8'd6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_PERIOD = 2'd0,
    REG_LED_COUNT    = 2'd1,
    REG_SAT_LEVEL    = 2'd2,
    REG_BRIGHTNESS   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [PERIOD_W-1:0]  frame_period_ms;
    logic [LED_CNT_W-1:0] led_count;
    logic [CH_W-1:0]      sat_level;
    logic [CH_W-1:0]      brightness;
  } cfg_t;

  // One frame to render: the new wave phase and the clamped LED count.
  typedef struct packed {
    logic [CH_W-1:0]      phase;
    logic [LED_CNT_W-1:0] n;
  } frame_cmd_t;

endpackage

// ===== sv/rwp_front.sv =====
// Front end: takes time samples, checks the frame period and issues frame commands.
module rwp_front (
  input  logic                          clk,
  input  logic                          rst,
  input  rwp_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rwp_pkg::TIME_W-1:0]    now_ms,
  input  logic                          cmd_full,
  output logic                          cmd_push,
  output rwp_pkg::frame_cmd_t           cmd
);
  import rwp_pkg::*;

  logic [TIME_W-1:0]    last_frame_time;
  logic [CH_W-1:0]      wave_phase;
  logic [TIME_W-1:0]    elapsed_ms;
  logic                 frame_due;
  logic [LED_CNT_W-1:0] n_clamped;

  assign in_ready   = !cmd_full;
  // Wrapping subtraction handles a rollover of the millisecond counter.
  assign elapsed_ms = now_ms - last_frame_time;
  assign frame_due  = elapsed_ms >= {{(TIME_W-PERIOD_W){1'b0}}, cfg.frame_period_ms};
  assign cmd_push   = in_valid && in_ready && frame_due;

  always_comb begin
    priority if (cfg.led_count == '0) begin
      n_clamped = LED_CNT_W'(1);
    end else if (cfg.led_count > LED_CNT_W'(MAX_LEDS)) begin
      n_clamped = LED_CNT_W'(MAX_LEDS);
    end else begin
      n_clamped = cfg.led_count;
    end
  end

  assign cmd.phase = wave_phase + CH_W'(1);
  assign cmd.n     = n_clamped;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_frame_time <= '0;
      wave_phase      <= '0;
    end else if (cmd_push) begin
      last_frame_time <= now_ms;
      wave_phase      <= cmd.phase;
    end
  end

endmodule

// ===== sv/rwp_cmd_fifo.sv =====
// Short command queue between the front end and the pixel engine.
module rwp_cmd_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  rwp_pkg::frame_cmd_t push_data,
  output logic                full,
  input  logic                pop,
  output rwp_pkg::frame_cmd_t pop_data,
  output logic                empty
);
  import rwp_pkg::*;

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  frame_cmd_t       slots [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = count == CNT_W'(FIFO_DEPTH);
  assign empty    = count == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
    logic [PTR_W-1:0] res;
    res = (ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
    return res;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/rwp_pixel_engine.sv =====
// Back end: walks the LEDs of a frame, divides out the hue offset and converts HSV to RGB.
module rwp_pixel_engine (
  input  logic                         clk,
  input  logic                         rst,
  input  rwp_pkg::cfg_t                cfg,
  input  logic                         cmd_empty,
  input  rwp_pkg::frame_cmd_t          cmd,
  output logic                         cmd_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rwp_pkg::IDX_W-1:0]    out_led_index,
  output logic [rwp_pkg::CH_W-1:0]     out_red,
  output logic [rwp_pkg::CH_W-1:0]     out_green,
  output logic [rwp_pkg::CH_W-1:0]     out_blue,
  output logic                         out_last_pixel
);
  import rwp_pkg::*;

  localparam int STEP_W = $clog2(CH_W);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DIV  = 6'b000010,
    ST_HSV1 = 6'b000100,
    ST_HSV2 = 6'b001000,
    ST_HSV3 = 6'b010000,
    ST_EMIT = 6'b100000
  } state_t;

  state_t               state;
  logic [CH_W-1:0]      phase;
  logic [LED_CNT_W-1:0] n;
  logic [IDX_W-1:0]     idx;
  logic [LED_CNT_W-1:0] div_rem;
  logic [CH_W-1:0]      div_quo;
  logic [STEP_W-1:0]    step;
  logic [2:0]           region;
  logic [CH_W-1:0]      rem6;
  logic [CH_W-1:0]      s_rem;
  logic [CH_W-1:0]      s_crem;
  logic [CH_W-1:0]      not_sat;
  logic [CH_W-1:0]      p_val;
  logic [CH_W-1:0]      q_val;
  logic [CH_W-1:0]      t_val;

  logic [LED_CNT_W:0]   div_trial;
  logic                 div_ge;
  logic [LED_CNT_W:0]   div_diff;
  logic [CH_W-1:0]      hue;
  logic [2:0]           region_w;
  logic [CH_W-1:0]      sector_base;
  logic [CH_W-1:0]      sector_off;
  logic [2*CH_W-1:0]    rem6_prod;
  logic [2*CH_W-1:0]    s_rem_prod;
  logic [2*CH_W-1:0]    s_crem_prod;
  logic [2*CH_W-1:0]    p_prod;
  logic [2*CH_W-1:0]    q_prod;
  logic [2*CH_W-1:0]    t_prod;
  logic                 out_free;
  logic                 is_last;
  logic [LED_CNT_W-1:0] idx_ext_next;
  logic [CH_W-1:0]      r_sel;
  logic [CH_W-1:0]      g_sel;
  logic [CH_W-1:0]      b_sel;

  assign cmd_pop = (state == ST_IDLE) && !cmd_empty;

  // Restoring division of idx*256 by n, one quotient bit per cycle.
  // The partial remainder stays below n, so it starts as idx itself.
  assign div_trial = {div_rem, 1'b0};
  assign div_ge    = div_trial >= {1'b0, n};
  assign div_diff  = div_trial - {1'b0, n};

  assign hue = phase + div_quo;

  always_comb begin
    priority if (hue >= CH_W'(5 * HUE_SECTOR)) begin
      region_w = 3'd5;
    end else if (hue >= CH_W'(4 * HUE_SECTOR)) begin
      region_w = 3'd4;
    end else if (hue >= CH_W'(3 * HUE_SECTOR)) begin
      region_w = 3'd3;
    end else if (hue >= CH_W'(2 * HUE_SECTOR)) begin
      region_w = 3'd2;
    end else if (hue >= HUE_SECTOR) begin
      region_w = 3'd1;
    end else begin
      region_w = 3'd0;
    end
  end

  assign sector_base = CH_W'(region_w) * HUE_SECTOR;
  assign sector_off  = hue - sector_base;
  assign rem6_prod   = {{CH_W{1'b0}}, sector_off} * {{CH_W{1'b0}}, REM_SCALE};

  assign s_rem_prod  = {{CH_W{1'b0}}, cfg.sat_level} * {{CH_W{1'b0}}, rem6};
  assign s_crem_prod = {{CH_W{1'b0}}, cfg.sat_level} * {{CH_W{1'b0}}, CH_MAX - rem6};

  assign p_prod = {{CH_W{1'b0}}, cfg.brightness} * {{CH_W{1'b0}}, not_sat};
  assign q_prod = {{CH_W{1'b0}}, cfg.brightness} * {{CH_W{1'b0}}, CH_MAX - s_rem};
  assign t_prod = {{CH_W{1'b0}}, cfg.brightness} * {{CH_W{1'b0}}, CH_MAX - s_crem};

  always_comb begin
    unique case (region)
      3'd0: begin
        r_sel = cfg.brightness; g_sel = t_val; b_sel = p_val;
      end
      3'd1: begin
        r_sel = q_val; g_sel = cfg.brightness; b_sel = p_val;
      end
      3'd2: begin
        r_sel = p_val; g_sel = cfg.brightness; b_sel = t_val;
      end
      3'd3: begin
        r_sel = p_val; g_sel = q_val; b_sel = cfg.brightness;
      end
      3'd4: begin
        r_sel = t_val; g_sel = p_val; b_sel = cfg.brightness;
      end
      default: begin
        r_sel = cfg.brightness; g_sel = p_val; b_sel = q_val;
      end
    endcase
  end

  assign out_free     = !out_valid || out_ready;
  assign idx_ext_next = {1'b0, idx} + LED_CNT_W'(1);
  assign is_last      = idx_ext_next == n;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (!cmd_empty) begin
            phase   <= cmd.phase;
            n       <= cmd.n;
            idx     <= '0;
            div_rem <= '0;
            step    <= '0;
            state   <= ST_DIV;
          end
        end
        ST_DIV: begin
          div_rem <= div_ge ? div_diff[LED_CNT_W-1:0] : div_trial[LED_CNT_W-1:0];
          div_quo <= {div_quo[CH_W-2:0], div_ge};
          step    <= step + STEP_W'(1);
          if (step == STEP_W'(CH_W - 1)) begin
            state <= ST_HSV1;
          end
        end
        ST_HSV1: begin
          region <= region_w;
          rem6   <= rem6_prod[CH_W-1:0];
          state  <= ST_HSV2;
        end
        ST_HSV2: begin
          s_rem   <= s_rem_prod[2*CH_W-1:CH_W];
          s_crem  <= s_crem_prod[2*CH_W-1:CH_W];
          not_sat <= CH_MAX - cfg.sat_level;
          state   <= ST_HSV3;
        end
        ST_HSV3: begin
          p_val <= p_prod[2*CH_W-1:CH_W];
          q_val <= q_prod[2*CH_W-1:CH_W];
          t_val <= t_prod[2*CH_W-1:CH_W];
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_led_index  <= idx;
            out_red        <= r_sel;
            out_green      <= g_sel;
            out_blue       <= b_sel;
            out_last_pixel <= is_last;
            if (is_last) begin
              state <= ST_IDLE;
            end else begin
              idx     <= idx_ext_next[IDX_W-1:0];
              div_rem <= idx_ext_next;
              step    <= '0;
              state   <= ST_DIV;
            end
          end
        end
      endcase
    end
  end

endmodule

// ===== sv/rainbow_wave_pixel_generator.sv =====
// Each frame first fetches its command; each pixel then passes through the 8-step hue divider,
// three HSV stages and the output load, which waits while the output is stalled, before the
// next pixel starts. A sample that starts no frame is taken whenever the queue is not full.
// A two-entry command queue lets the input keep taking samples while a frame renders.
// Reset is synchronous and active high: it restores the register defaults, clears the
// frame time, wave phase, queue and output valid.
module rainbow_wave_pixel_generator (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [rwp_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [31:0] now_ms
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [5:0] led_index, [13:6] red, [21:14] green, [29:22] blue, [31:30] zero
  output logic [rwp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                               m_axis_tlast,  // last_pixel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rwp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rwp_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import rwp_pkg::*;

  cfg_t             cfg;
  logic             cmd_push;
  logic             cmd_full;
  logic             cmd_pop;
  logic             cmd_empty;
  frame_cmd_t       cmd_in;
  frame_cmd_t       cmd_out;
  logic [IDX_W-1:0] led_index;
  logic [CH_W-1:0]  red;
  logic [CH_W-1:0]  green;
  logic [CH_W-1:0]  blue;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_period_ms <= PERIOD_W'(100);
      cfg.led_count       <= LED_CNT_W'(64);
      cfg.sat_level       <= CH_MAX;
      cfg.brightness      <= CH_MAX;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_PERIOD: cfg.frame_period_ms <= cfg_data[PERIOD_W-1:0];
        REG_LED_COUNT:    cfg.led_count       <= cfg_data[LED_CNT_W-1:0];
        REG_SAT_LEVEL:    cfg.sat_level       <= cfg_data[CH_W-1:0];
        REG_BRIGHTNESS:   cfg.brightness      <= cfg_data[CH_W-1:0];
      endcase
    end
  end

  rwp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .now_ms   (s_axis_tdata[TIME_W-1:0]),
    .cmd_full (cmd_full),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  rwp_cmd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_data (cmd_in),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .pop_data  (cmd_out),
    .empty     (cmd_empty)
  );

  rwp_pixel_engine u_engine (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .cmd_empty      (cmd_empty),
    .cmd            (cmd_out),
    .cmd_pop        (cmd_pop),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .out_led_index  (led_index),
    .out_red        (red),
    .out_green      (green),
    .out_blue       (blue),
    .out_last_pixel (m_axis_tlast)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W-OUT_PAYLOAD_W){1'b0}}, blue, green, red, led_index};

endmodule

// ===== sv/rwp_checker.sv =====
// Port-level checks for the pixel generator, bound to the top level.
module rwp_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [rwp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tlast
);
  import rwp_pkg::*;

  // LED index expected on the next output transaction.
  logic [IDX_W-1:0] exp_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_idx <= '0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      exp_idx <= m_axis_tlast ? '0 : m_axis_tdata[IDX_W-1:0] + IDX_W'(1);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output changed while stalled");

  a_index_order: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready |-> m_axis_tdata[IDX_W-1:0] == exp_idx)
    else $error("pixel index out of sequence");

  a_reset_quiet: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:OUT_PAYLOAD_W] == '0)
    else $error("padding bits of output data not zero");

endmodule

bind rainbow_wave_pixel_generator rwp_checker u_rwp_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== verif/tb_top.sv =====
// Testbench for the rainbow wave pixel generator: time samples in, predicted LED colors checked out.
module tb_top;
  import rwp_pkg::*;

  typedef struct {
    logic [IDX_W-1:0] led;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic             last;
  } pixel_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Predictor state: register copy, last frame time and wave phase.
  cfg_t              strip_cfg;
  logic [TIME_W-1:0] frame_time;
  logic [CH_W-1:0]   phase;
  pixel_t            pixel_q[$];
  int                error_count = 0;
  bit                no_gaps = 1'b0;
  int                stall_left = 0;

  rainbow_wave_pixel_generator dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("tb_top failed");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic void hsv_to_rgb(input logic [CH_W-1:0] hue, input logic [CH_W-1:0] sat,
                                     input logic [CH_W-1:0] val, output logic [CH_W-1:0] r,
                                     output logic [CH_W-1:0] g, output logic [CH_W-1:0] b);
    int unsigned h, s, v, sector, frac, p, q, t, top;
    h = 32'(hue);
    s = 32'(sat);
    v = 32'(val);
    top = 32'(CH_MAX);
    sector = h / 32'(HUE_SECTOR);
    frac = ((h - sector * 32'(HUE_SECTOR)) * 32'(REM_SCALE)) & top;
    p = (v * (top - s)) >> 8;
    q = (v * (top - ((s * frac) >> 8))) >> 8;
    t = (v * (top - ((s * (top - frac)) >> 8))) >> 8;
    case (sector)
      0: begin
        r = CH_W'(v); g = CH_W'(t); b = CH_W'(p);
      end
      1: begin
        r = CH_W'(q); g = CH_W'(v); b = CH_W'(p);
      end
      2: begin
        r = CH_W'(p); g = CH_W'(v); b = CH_W'(t);
      end
      3: begin
        r = CH_W'(p); g = CH_W'(q); b = CH_W'(v);
      end
      4: begin
        r = CH_W'(t); g = CH_W'(p); b = CH_W'(v);
      end
      default: begin
        r = CH_W'(v); g = CH_W'(p); b = CH_W'(q);
      end
    endcase
  endfunction

  // Applies one accepted time sample and queues the pixels of the frame it starts, if any.
  function automatic void predict_sample(input logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] elapsed;
    int unsigned       n;
    int unsigned       hue;
    pixel_t            px;
    elapsed = now - frame_time;
    if (elapsed < TIME_W'(strip_cfg.frame_period_ms)) begin
      return;
    end
    frame_time = now;
    phase = phase + 8'd1;
    n = 32'(strip_cfg.led_count);
    if (n < 1) begin
      n = 1;
    end
    if (n > MAX_LEDS) begin
      n = MAX_LEDS;
    end
    for (int unsigned i = 0; i < n; i++) begin
      hue = (32'(phase) + (i * 256) / n) & 32'(CH_MAX);
      px.led = IDX_W'(i);
      hsv_to_rgb(CH_W'(hue), strip_cfg.sat_level, strip_cfg.brightness,
                 px.red, px.green, px.blue);
      px.last = (i == n - 1);
      pixel_q.push_back(px);
    end
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin : pixel_check
    pixel_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pixel_q.size() == 0) begin
        $error("led_index: expected no pixel, actual %0d", m_axis_tdata[IDX_W-1:0]);
        error_count++;
      end else begin
        want = pixel_q.pop_front();
        check_field("led_index", 32'(want.led), 32'(m_axis_tdata[IDX_W-1:0]));
        check_field("red", 32'(want.red), 32'(m_axis_tdata[IDX_W +: CH_W]));
        check_field("green", 32'(want.green), 32'(m_axis_tdata[IDX_W + CH_W +: CH_W]));
        check_field("blue", 32'(want.blue), 32'(m_axis_tdata[IDX_W + 2 * CH_W +: CH_W]));
        check_field("last_pixel", 32'(want.last), 32'(m_axis_tlast));
      end
    end
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  // Valid stays high after a transaction so back-to-back samples never toggle it in one step.
  task automatic send_sample(input logic [TIME_W-1:0] now);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= now;
    do @(posedge clk); while (!s_axis_tready);
    predict_sample(now);
  endtask

  // Samples that start no frame leave nothing queued, so also wait on after the last pixel is checked.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_config(input int unsigned period, input int unsigned count,
                            input int unsigned sat, input int unsigned bright);
    logic [CFG_DATA_W-1:0] vals[4];
    cfg_reg_t              sel;
    vals[0] = CFG_DATA_W'(period);
    vals[1] = CFG_DATA_W'(count);
    vals[2] = CFG_DATA_W'(sat);
    vals[3] = CFG_DATA_W'(bright);
    wait_idle();
    for (int k = 0; k < 4; k++) begin
      sel = cfg_reg_t'(k);
      cfg_valid <= 1'b1;
      cfg_index <= sel;
      cfg_data <= vals[k];
      do @(posedge clk); while (!cfg_ready);
      case (sel)
        REG_FRAME_PERIOD: strip_cfg.frame_period_ms = vals[k][PERIOD_W-1:0];
        REG_LED_COUNT:    strip_cfg.led_count = vals[k][LED_CNT_W-1:0];
        REG_SAT_LEVEL:    strip_cfg.sat_level = vals[k][CH_W-1:0];
        REG_BRIGHTNESS:   strip_cfg.brightness = vals[k][CH_W-1:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic int unsigned pick_level();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  task automatic random_config();
    int unsigned period, count;
    case ($urandom_range(0, 4))
      0: period = 0;
      1: period = $urandom_range(1, 20);
      2: period = $urandom_range(21, 1000);
      3: period = 65535;
      default: period = $urandom_range(0, 65535);
    endcase
    case ($urandom_range(0, 9))
      7: count = 64;
      8: count = $urandom_range(13, 63);
      9: count = $urandom_range(0, 1) ? 0 : $urandom_range(65, 127);
      default: count = $urandom_range(1, 12);
    endcase
    set_config(period, count, pick_level(), pick_level());
  endtask

  // Mostly samples that land just past the period; the rest arrive early or at random.
  function automatic logic [TIME_W-1:0] random_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      return frame_time + TIME_W'(strip_cfg.frame_period_ms) + TIME_W'($urandom_range(0, 3));
    end else if (r < 90 && strip_cfg.frame_period_ms != '0) begin
      return frame_time + TIME_W'($urandom_range(0, 32'(strip_cfg.frame_period_ms) - 1));
    end
    return $urandom;
  endfunction

  task automatic test_default_timing();
    send_sample(32'd0);
    send_sample(32'd99);
    send_sample(32'd100);
    send_sample(32'd150);
    send_sample(32'd200);
    send_sample(32'hFFFF_FFFF);
    // The clock wraps here: 50 is too soon after the all-ones time, 99 is exactly one period.
    send_sample(32'd50);
    send_sample(32'd99);
  endtask

  task automatic test_register_extremes();
    set_config(0, 0, 0, 255);
    send_sample(32'd1000);
    send_sample(32'd1000);
    set_config(0, 127, 128, 0);
    send_sample(32'd7);
    set_config(0, 100, 255, 1);
    send_sample(32'd8);
    set_config(65535, 64, 255, 255);
    send_sample(32'd8 + 32'd65534);
    send_sample(32'd8 + 32'd65535);
    set_config(1, 3, 200, 180);
    send_sample(32'hAAAA_AAAA);
    send_sample(32'h5555_5555);
    send_sample(32'h5555_5555);
  endtask

  task automatic test_random_settings();
    for (int ph = 0; ph < 5; ph++) begin
      random_config();
      repeat (32) send_sample(random_sample());
    end
  endtask

  task automatic test_no_stalls();
    set_config($urandom_range(0, 5), $urandom_range(1, 8), pick_level(), pick_level());
    no_gaps = 1'b1;
    repeat (16) send_sample(random_sample());
    wait_idle();
    no_gaps = 1'b0;
  endtask

  // The sender holds off mid-stream until the strip has drained completely.
  task automatic test_drain_pause();
    set_config($urandom_range(0, 30), $urandom_range(2, 10), pick_level(), pick_level());
    repeat (10) send_sample(random_sample());
    wait_idle();
    repeat (10) send_sample(random_sample());
  endtask

  initial begin
    strip_cfg = '{frame_period_ms: 16'd100, led_count: 7'd64, sat_level: 8'hFF,
                  brightness: 8'hFF};
    frame_time = '0;
    phase = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_default_timing();
    test_register_extremes();
    test_random_settings();
    test_no_stalls();
    test_drain_pause();
    wait_idle();
    if (error_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
